// ===== rtl/cdu_pkg.sv =====
`timescale 1ns / 1ps

package cdu_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_CHECK,
    ST_GCD_WAIT,
    ST_FAC_INIT,
    ST_FAC_CHECK,
    ST_FAC_WAIT,
    ST_FINISH
  } cdu_state_e;

endpackage

// ===== rtl/cdu_rem.sv =====
`timescale 1ns / 1ps

module cdu_rem #(
  parameter int unsigned Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [Width-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] dvd_q, dvd_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [Width:0]   trial;
  logic [Width:0]   diff;

  // One restoring step per cycle: bring down the next dividend bit and
  // subtract the divisor when it fits.
  assign trial = {rem_q, dvd_q[Width-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Width);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, dvs_q}) ? diff[Width-1:0] : trial[Width-1:0];
      dvd_d = {dvd_q[Width-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/common_divisor_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  tdata (lowest bits first)              tuser  tlast
// s_axis    in         operand_a, operand_b                   -      -
// m_axis    out        greatest_divisor, smallest_divisor     -      -
//
// Every remainder comes from one shared restoring unit. Each item costs one remainder per Euclid
// step and one per trial divisor up to the square root of the greatest divisor.
// Reset clears the sequencer and the output valid flag; no clearing pass.
// s_axis is ready only in idle, so a result waiting on m_axis does not stop the next
// transfer, but it holds the sequencer in its final state once that item is done.

module common_divisor_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // operand_a, operand_b
  input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // greatest_divisor, smallest_divisor
  output logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]      m_axis_tdata
);

  import cdu_pkg::*;

  localparam int unsigned OpW   = OPERAND_WIDTH;
  localparam int unsigned DataW = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int unsigned SqW   = OPERAND_WIDTH + 2;

  cdu_state_e       state_q, state_d;
  logic [OpW-1:0]   x_q, x_d;
  logic [OpW-1:0]   y_q, y_d;
  logic [OpW-1:0]   g_q, g_d;
  logic [OpW-1:0]   d_q, d_d;
  logic [SqW-1:0]   sq_q, sq_d;
  logic [OpW-1:0]   s_q, s_d;
  logic             zero_q, zero_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;

  logic             in_fire;
  logic             out_load;
  logic             rem_start;
  logic [OpW-1:0]   rem_dividend;
  logic [OpW-1:0]   rem_divisor;
  logic             rem_busy;
  logic             rem_done;
  logic [OpW-1:0]   rem_value;
  logic             sq_over;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
  assign sq_over  = sq_q > {2'b00, g_q};

  cdu_rem #(
    .Width (OpW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (rem_divisor),
    .busy_o     (rem_busy),
    .done_o     (rem_done),
    .rem_o      (rem_value)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_fire) state_d = ST_GCD_CHECK;
      ST_GCD_CHECK: state_d = (y_q == '0) ? ST_FAC_INIT : ST_GCD_WAIT;
      ST_GCD_WAIT:  if (rem_done) state_d = ST_GCD_CHECK;
      ST_FAC_INIT:  state_d = (zero_q || g_q < OpW'(2)) ? ST_FINISH : ST_FAC_CHECK;
      ST_FAC_CHECK: state_d = sq_over ? ST_FINISH : ST_FAC_WAIT;
      ST_FAC_WAIT: begin
        if (rem_done) begin
          state_d = (rem_value == '0) ? ST_FINISH : ST_FAC_CHECK;
        end
      end
      ST_FINISH:    if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    rem_start     = 1'b0;
    rem_dividend  = g_q;
    rem_divisor   = d_q;
    x_d           = x_q;
    y_d           = y_q;
    g_d           = g_q;
    d_d           = d_q;
    sq_d          = sq_q;
    s_d           = s_q;
    zero_d        = zero_q;
    case (state_q)
      ST_IDLE: begin
        x_d    = s_axis_tdata[OpW-1:0];
        y_d    = s_axis_tdata[2*OpW-1:OpW];
        zero_d = (s_axis_tdata[OpW-1:0] == '0) || (s_axis_tdata[2*OpW-1:OpW] == '0);
      end
      ST_GCD_CHECK: begin
        rem_dividend = x_q;
        rem_divisor  = y_q;
        if (y_q == '0) begin
          g_d = (x_q == '0) ? OpW'(1) : x_q;
        end else begin
          rem_start = 1'b1;
        end
      end
      ST_GCD_WAIT: begin
        if (rem_done) begin
          x_d = y_q;
          y_d = rem_value;
        end
      end
      ST_FAC_INIT: begin
        s_d  = OpW'(1);
        d_d  = OpW'(2);
        sq_d = SqW'(4);
      end
      ST_FAC_CHECK: begin
        if (sq_over) begin
          s_d = g_q;
        end else begin
          rem_start = 1'b1;
        end
      end
      ST_FAC_WAIT: begin
        if (rem_done) begin
          if (rem_value == '0) begin
            s_d = d_q;
          end else begin
            // Next square follows from (d + 1)^2 = d^2 + 2d + 1.
            sq_d = sq_q + {1'b0, d_q, 1'b1};
            d_d  = d_q + OpW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = DataW'({s_q, g_q});
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    g_q        <= g_d;
    d_q        <= d_d;
    sq_q       <= sq_d;
    s_q        <= s_d;
    zero_q     <= zero_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_rem_idle_on_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_start |-> !rem_busy)
    else $error("remainder unit started while busy");

  a_rem_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == ST_GCD_WAIT || state_q == ST_FAC_WAIT))
    else $error("remainder finished outside a wait state");

  a_trial_divisor_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FAC_WAIT |-> d_q >= OpW'(2))
    else $error("trial divisor below two");

  a_result_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (g_q != '0 && s_q != '0))
    else $error("zero divisor about to be delivered");

endmodule
